### hw/rtl/lpq_pkg.sv
// shared types and codes of the loopback packet queue
package lpq_pkg;

   localparam int KIND_W    = 2;
   localparam int LEN_OUT_W = 7;

   localparam logic [KIND_W-1:0] KIND_SEND_BYTE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SEND_EMPTY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RECEIVE    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED     = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              socket;
      logic [7:0]        data_byte;
      logic              last;
   } lpq_req_type;

   typedef struct packed {
      logic                 packet_present;
      logic [7:0]           data_byte_res;
      logic [LEN_OUT_W-1:0] message_length;
      logic                 last_res;
   } lpq_rsp_type;

endpackage

### hw/rtl/loopback_packet_queue_unit.sv
// loopback packet queue: two crossed message rings in one byte memory
//
// Request channel (req_*): one transaction per item. A send byte or send
// empty transaction writes the queue of the other side and returns no
// response; a receive transaction reads the issuing side's own queue.
// Response channel (rsp_*): a receive returns one transaction per stored
// byte (last_res on the final one), or a single transaction with zero data
// when the queue is empty or the message has no bytes.
// Sends are accepted back to back. A receive blocks the request channel
// while its bytes are read out of the message memory, one byte per cycle
// while the receiver keeps up, through its single read port. Each byte
// passes the read stage register and then the response queue before it
// shows on rsp_*. A two-entry response queue sits between the memory read
// and rsp_*; when the receiver stalls, reads pause once the read stage and
// the queue together hold two entries, and nothing is lost. Requests are
// taken again once the last read of a receive is issued, even while its
// responses still wait. Reset empties both queues at once; message memory
// and lengths need no clearing since a slot's bytes and length are only
// used after they have been written.
module loopback_packet_queue_unit #(
   parameter int QUEUE_DEPTH = 4,
   parameter int MSG_BYTES   = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lpq_pkg::lpq_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lpq_pkg::lpq_rsp_type rsp_data
);
   import lpq_pkg::*;

   localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W     = CNT_W + 1;
   localparam int LEN_W     = $clog2(MSG_BYTES + 1);
   localparam int OFF_W     = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
   localparam int ADDR_W    = 1 + SLOT_W + OFF_W;
   localparam int MEM_DEPTH = 2 ** ADDR_W;
   localparam int LTAB_D    = 2 ** (SLOT_W + 1);

   localparam logic [CNT_W-1:0]  QD_CNT   = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0]  QD_SUM   = SUM_W'(QUEUE_DEPTH);
   localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(QUEUE_DEPTH - 1);
   localparam logic [LEN_W-1:0]  MB_LEN   = LEN_W'(MSG_BYTES);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_STREAM = 2'b10
   } state_type;

   // per-queue control
   logic [SLOT_W-1:0] read_slot_ff [2];
   logic [SLOT_W-1:0] read_slot_in [2];
   logic [CNT_W-1:0]  count_ff     [2];
   logic [CNT_W-1:0]  count_in     [2];
   logic [LEN_W-1:0]  wr_off_ff    [2];
   logic [LEN_W-1:0]  wr_off_in    [2];
   logic              busy_ff      [2];
   logic              busy_in      [2];
   logic [LEN_W-1:0]  len_tab_ff   [LTAB_D];

   logic [7:0] msg_mem [MEM_DEPTH];
   logic [7:0] mem_rdata_ff;

   state_type         st_ff, st_in;
   logic              gen_q_ff, gen_q_in;
   logic [SLOT_W-1:0] gen_slot_ff, gen_slot_in;
   logic [LEN_W-1:0]  gen_off_ff, gen_off_in;
   logic [LEN_W-1:0]  gen_len_ff, gen_len_in;
   logic              gen_present_ff, gen_present_in;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_present_ff, s1_last_ff, s1_from_mem_ff;
   logic [LEN_W-1:0]  s1_len_ff;

   lpq_rsp_type fifo_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  fifo_cnt_ff, fifo_cnt_in;

   logic              accept, is_send, is_recv;
   logic              q;
   logic [SLOT_W-1:0] rs, cl_rs, ws;
   logic [CNT_W-1:0]  cnt, cl_cnt;
   logic [LEN_W-1:0]  cl_off;
   logic [SUM_W-1:0]  ws_sum;
   logic              mem_we, len_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [SLOT_W-1:0] len_wslot;
   logic [LEN_W-1:0]  len_wdata;
   logic              issue, issue_last, pop;
   logic [2:0]        occ;

   assign req_ready = (st_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_send   = (req_data.kind == KIND_SEND_BYTE) || (req_data.kind == KIND_SEND_EMPTY);
   assign is_recv   = (req_data.kind == KIND_RECEIVE);
   assign q         = is_recv ? req_data.socket : ~req_data.socket;
   assign rs        = read_slot_ff[q];
   assign cnt       = count_ff[q];

   // a new send claims a slot, dropping the oldest message when full
   always_comb begin
      cl_rs  = rs;
      cl_cnt = cnt;
      cl_off = busy_ff[q] ? wr_off_ff[q] : '0;
      if (!busy_ff[q] && (cnt == QD_CNT)) begin
         cl_rs  = (rs == SLOT_TOP) ? '0 : rs + SLOT_W'(1);
         cl_cnt = QD_CNT - CNT_W'(1);
      end
      ws_sum = SUM_W'(cl_rs) + SUM_W'(cl_cnt);
      if (ws_sum >= QD_SUM) begin
         ws_sum = ws_sum - QD_SUM;
      end
      ws = ws_sum[SLOT_W-1:0];
   end

   always_comb begin
      read_slot_in   = read_slot_ff;
      count_in       = count_ff;
      wr_off_in      = wr_off_ff;
      busy_in        = busy_ff;
      mem_we         = 1'b0;
      mem_waddr      = {q, ws, cl_off[OFF_W-1:0]};
      len_we         = 1'b0;
      len_wslot      = ws;
      len_wdata      = cl_off;
      st_in          = st_ff;
      gen_q_in       = gen_q_ff;
      gen_slot_in    = gen_slot_ff;
      gen_off_in     = gen_off_ff;
      gen_len_in     = gen_len_ff;
      gen_present_in = gen_present_ff;

      if (accept && is_send) begin
         read_slot_in[q] = cl_rs;
         count_in[q]     = cl_cnt;
         wr_off_in[q]    = cl_off;
         busy_in[q]      = 1'b1;
         if (req_data.kind == KIND_SEND_BYTE) begin
            if (cl_off < MB_LEN) begin
               mem_we       = 1'b1;
               wr_off_in[q] = cl_off + LEN_W'(1);
            end
         end
         // commit on an empty send or on the last byte
         if ((req_data.kind == KIND_SEND_EMPTY) || req_data.last) begin
            len_we       = 1'b1;
            len_wdata    = wr_off_in[q];
            count_in[q]  = cl_cnt + CNT_W'(1);
            wr_off_in[q] = '0;
            busy_in[q]   = 1'b0;
         end
      end

      if (accept && is_recv) begin
         st_in       = ST_STREAM;
         gen_q_in    = q;
         gen_slot_in = rs;
         gen_off_in  = '0;
         if (cnt == '0) begin
            gen_len_in     = '0;
            gen_present_in = 1'b0;
         end else begin
            gen_len_in      = len_tab_ff[{q, rs}];
            gen_present_in  = 1'b1;
            read_slot_in[q] = (rs == SLOT_TOP) ? '0 : rs + SLOT_W'(1);
            count_in[q]     = cnt - CNT_W'(1);
         end
      end

      unique case (st_ff)
         ST_IDLE: begin
         end
         ST_STREAM: begin
            if (issue) begin
               gen_off_in = gen_off_ff + LEN_W'(1);
               if (issue_last) begin
                  st_in = ST_IDLE;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // read issue: keep read stage plus response queue within two entries
   assign pop        = rsp_valid && rsp_ready;
   assign occ        = 3'(fifo_cnt_ff) + 3'(s1_valid_ff) - 3'(pop);
   assign issue      = (st_ff == ST_STREAM) && (occ < 3'd2);
   assign issue_last = (gen_len_ff == '0) || ((gen_off_ff + LEN_W'(1)) == gen_len_ff);
   assign mem_raddr  = {gen_q_ff, gen_slot_ff, gen_off_ff[OFF_W-1:0]};
   assign s1_valid_in = issue;
   assign fifo_cnt_in = fifo_cnt_ff + 2'(s1_valid_ff) - 2'(pop);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         msg_mem[mem_waddr] <= req_data.data_byte;
      end
      if (issue) begin
         mem_rdata_ff <= msg_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_tab_ff[{q, len_wslot}] <= len_wdata;
      end
      gen_q_ff       <= gen_q_in;
      gen_slot_ff    <= gen_slot_in;
      gen_off_ff     <= gen_off_in;
      gen_len_ff     <= gen_len_in;
      gen_present_ff <= gen_present_in;
      if (issue) begin
         s1_present_ff  <= gen_present_ff;
         s1_last_ff     <= issue_last;
         s1_from_mem_ff <= (gen_len_ff != '0);
         s1_len_ff      <= gen_len_ff;
      end
      if (s1_valid_ff) begin
         fifo_ff[wr_ptr_ff].packet_present <= s1_present_ff;
         fifo_ff[wr_ptr_ff].data_byte_res  <= s1_from_mem_ff ? mem_rdata_ff : 8'd0;
         fifo_ff[wr_ptr_ff].message_length <= LEN_OUT_W'(s1_len_ff);
         fifo_ff[wr_ptr_ff].last_res       <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            read_slot_ff[i] <= '0;
            count_ff[i]     <= '0;
            wr_off_ff[i]    <= '0;
            busy_ff[i]      <= 1'b0;
         end
         st_ff       <= ST_IDLE;
         s1_valid_ff <= 1'b0;
         fifo_cnt_ff <= '0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
      end else begin
         read_slot_ff <= read_slot_in;
         count_ff     <= count_in;
         wr_off_ff    <= wr_off_in;
         busy_ff      <= busy_in;
         st_ff        <= st_in;
         s1_valid_ff  <= s1_valid_in;
         fifo_cnt_ff  <= fifo_cnt_in;
         if (s1_valid_ff) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   assign rsp_valid = (fifo_cnt_ff != 2'd0);
   assign rsp_data  = fifo_ff[rd_ptr_ff];

endmodule

### hw/rtl/lpq_checker.sv
// port-level checks of the loopback packet queue, bound to the top level
module lpq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input lpq_pkg::lpq_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input lpq_pkg::lpq_rsp_type rsp_data
);
   import lpq_pkg::*;

   // stalled response transaction stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   // reset empties the response queue
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // an accepted receive blocks the request channel while it streams
   a_recv_block: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.kind == KIND_RECEIVE) |=> !req_ready)
      else $error("request accepted while a receive streams");

   // an empty queue answers with a single zero transaction
   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.packet_present |->
         rsp_data.last_res && (rsp_data.message_length == '0) &&
         (rsp_data.data_byte_res == 8'd0))
      else $error("malformed empty-queue response");

   // a message without bytes is one transaction with zero data
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.packet_present && (rsp_data.message_length == '0) |->
         rsp_data.last_res && (rsp_data.data_byte_res == 8'd0))
      else $error("malformed zero-length message response");

endmodule

bind loopback_packet_queue_unit lpq_checker u_lpq_checker (.*);

### test/testbench.sv
// testbench for the loopback packet queue: directed and random traffic against a predictor
`timescale 1ns / 100ps

module testbench;
   import lpq_pkg::*;

   localparam int QUEUE_DEPTH = 4;
   localparam int MSG_BYTES   = 64;
   localparam int CYCLE_LIMIT = 1000000;

   class queue_mirror;
      logic [7:0]  slot_bytes [2][QUEUE_DEPTH][MSG_BYTES];
      logic [6:0]  slot_len [2][QUEUE_DEPTH];
      int unsigned head [2];
      int unsigned held [2];
      int unsigned fill [2];
      bit          open [2];
      lpq_rsp_type due_replies [$];
      int unsigned faults;

      function int unsigned tail_slot(input int q);
         return (head[q] + held[q]) % QUEUE_DEPTH;
      endfunction

      // a full ring loses its oldest message when a new send claims a slot
      function void open_message(input int q);
         if (held[q] >= QUEUE_DEPTH) begin
            head[q] = (head[q] + 1) % QUEUE_DEPTH;
            held[q] = QUEUE_DEPTH - 1;
         end
         fill[q] = 0;
         open[q] = 1'b1;
      endfunction

      function void close_message(input int q);
         slot_len[q][tail_slot(q)] = fill[q][6:0];
         held[q]++;
         fill[q] = 0;
         open[q] = 1'b0;
      endfunction

      function void add_reply(input bit present, input logic [7:0] b,
                              input logic [6:0] len, input bit fin);
         lpq_rsp_type r;
         r.packet_present = present;
         r.data_byte_res  = b;
         r.message_length = len;
         r.last_res       = fin;
         due_replies.push_back(r);
      endfunction

      function void take_request(input lpq_req_type t);
         int q;
         int unsigned slot;
         int unsigned len;
         case (t.kind)
            KIND_SEND_BYTE: begin
               q = int'(t.socket ^ 1'b1);
               if (!open[q]) open_message(q);
               if (fill[q] < MSG_BYTES) begin
                  slot_bytes[q][tail_slot(q)][fill[q]] = t.data_byte;
                  fill[q]++;
               end
               if (t.last) close_message(q);
            end
            KIND_SEND_EMPTY: begin
               q = int'(t.socket ^ 1'b1);
               if (!open[q]) open_message(q);
               close_message(q);
            end
            KIND_RECEIVE: begin
               q = int'(t.socket);
               if (held[q] == 0) begin
                  add_reply(1'b0, 8'h00, 7'd0, 1'b1);
               end else begin
                  slot = head[q];
                  len = 32'(slot_len[q][slot]);
                  head[q] = (slot + 1) % QUEUE_DEPTH;
                  held[q]--;
                  if (len == 0) begin
                     add_reply(1'b1, 8'h00, 7'd0, 1'b1);
                  end else begin
                     for (int i = 0; i < len; i++)
                        add_reply(1'b1, slot_bytes[q][slot][i], len[6:0], i == len - 1);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_reply(input lpq_rsp_type act);
         lpq_rsp_type e;
         if (due_replies.size() == 0) begin
            $display("%0t: unexpected reply present=%0d byte=%02h len=%0d last=%0d",
                     $time, act.packet_present, act.data_byte_res, act.message_length,
                     act.last_res);
            faults++;
            return;
         end
         e = due_replies.pop_front();
         if (act.packet_present !== e.packet_present || act.data_byte_res !== e.data_byte_res ||
             act.message_length !== e.message_length || act.last_res !== e.last_res) begin
            $display("%0t: reply mismatch expected present=%0d byte=%02h len=%0d last=%0d",
                     $time, e.packet_present, e.data_byte_res, e.message_length, e.last_res);
            $display("%0t:                actual present=%0d byte=%02h len=%0d last=%0d",
                     $time, act.packet_present, act.data_byte_res, act.message_length,
                     act.last_res);
            faults++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   lpq_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   lpq_rsp_type rsp_data;

   queue_mirror mirror = new();
   int unsigned cycles = 0;
   int unsigned issued = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   loopback_packet_queue_unit #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .MSG_BYTES  (MSG_BYTES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) mirror.check_reply(rsp_data);
   end

   function automatic lpq_req_type make_req(input logic [1:0] kind, input logic side,
                                            input logic [7:0] b, input logic fin);
      lpq_req_type t;
      t.kind      = kind;
      t.socket    = side;
      t.data_byte = b;
      t.last      = fin;
      return t;
   endfunction

   task automatic push_request(input lpq_req_type t);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
      mirror.take_request(t);
      if (t.kind != KIND_UNUSED) issued++;
   endtask

   // one message from side; cut_short ends it with an empty send instead of a last mark
   task automatic send_message(input logic side, input int len, input bit cut_short);
      if (len == 0) begin
         push_request(make_req(KIND_SEND_EMPTY, side, 8'($urandom_range(255)),
                               1'($urandom_range(1))));
      end else begin
         for (int i = 0; i < len; i++) begin
            // receives in the middle of a send must not see the partial message
            if ($urandom_range(15) == 0)
               push_request(make_req(KIND_RECEIVE, 1'($urandom_range(1)),
                                     8'($urandom_range(255)), 1'($urandom_range(1))));
            push_request(make_req(KIND_SEND_BYTE, side, 8'($urandom_range(255)),
                                  (i == len - 1) && !cut_short));
         end
         if (cut_short)
            push_request(make_req(KIND_SEND_EMPTY, side, 8'($urandom_range(255)),
                                  1'($urandom_range(1))));
      end
   endtask

   task automatic directed_items();
      push_request(make_req(KIND_RECEIVE, 1'b0, 8'h00, 1'b0));
      push_request(make_req(KIND_RECEIVE, 1'b1, 8'hff, 1'b1));
      push_request(make_req(KIND_UNUSED, 1'b1, 8'hff, 1'b1));
      push_request(make_req(KIND_SEND_EMPTY, 1'b1, 8'h00, 1'b0));
      push_request(make_req(KIND_RECEIVE, 1'b0, 8'h00, 1'b0));
      push_request(make_req(KIND_SEND_BYTE, 1'b0, 8'h00, 1'b0));
      push_request(make_req(KIND_SEND_BYTE, 1'b0, 8'hff, 1'b1));
      push_request(make_req(KIND_RECEIVE, 1'b1, 8'h00, 1'b0));
      // open send stays hidden, then an empty send closes it
      push_request(make_req(KIND_SEND_BYTE, 1'b1, 8'ha5, 1'b0));
      push_request(make_req(KIND_RECEIVE, 1'b0, 8'h00, 1'b0));
      push_request(make_req(KIND_SEND_EMPTY, 1'b1, 8'h00, 1'b0));
      push_request(make_req(KIND_RECEIVE, 1'b0, 8'h00, 1'b0));
      // five messages into a four-slot ring drop the first
      for (int i = 1; i <= 5; i++)
         push_request(make_req(KIND_SEND_BYTE, 1'b1, i[7:0], 1'b1));
      for (int i = 0; i < 5; i++)
         push_request(make_req(KIND_RECEIVE, 1'b0, 8'h00, 1'b0));
   endtask

   task automatic random_items(input int goal);
      int unsigned mark;
      int unsigned pick;
      int len;
      mark = issued;
      while (issued - mark < goal) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            len = ($urandom_range(24) == 0) ? int'($urandom_range(70, 60))
                                            : int'($urandom_range(8));
            send_message(1'($urandom_range(1)), len, $urandom_range(9) == 0);
         end else if (pick < 90) begin
            push_request(make_req(KIND_RECEIVE, 1'($urandom_range(1)),
                                  8'($urandom_range(255)), 1'($urandom_range(1))));
         end else begin
            push_request(make_req(2'($urandom_range(3)), 1'($urandom_range(1)),
                                  8'($urandom_range(255)), 1'($urandom_range(1))));
         end
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (mirror.due_replies.size() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned idle_plan [4][2];
      idle_plan = '{'{0, 0}, '{47, 0}, '{0, 47}, '{35, 35}};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_plan[p][0];
         recv_stall_pct = idle_plan[p][1];
         if (p == 0) directed_items();
         random_items(125);
         // sender holds off until every reply is back
         drain();
      end
      repeat (10) @(posedge clock);
      if (mirror.faults == 0 && mirror.due_replies.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### loopback_packet_queue_unit.f
hw/rtl/lpq_pkg.sv
hw/rtl/loopback_packet_queue_unit.sv
hw/rtl/lpq_checker.sv
test/testbench.sv
